// File: design/u16d_pkg.sv
// ---------------------------------------------------------------------------
// u16d_pkg
// Shared types and constants for the UTF-16 byte stream decoder.
// ---------------------------------------------------------------------------
package u16d_pkg;

    localparam int unsigned QUEUE_DEPTH = 4;

    localparam int unsigned BYTE_W = 8;
    localparam int unsigned UNIT_W = 16;
    localparam int unsigned CP_W   = 21;
    localparam int unsigned SUR_W  = 10;

    localparam logic [5:0]      SUR_HIGH_TAG = 6'b110110;
    localparam logic [5:0]      SUR_LOW_TAG  = 6'b110111;
    localparam logic [CP_W-1:0] SUPP_BASE    = 21'h010000;

    localparam logic STATUS_OK  = 1'b0;
    localparam logic STATUS_ERR = 1'b1;

    // One queued word: up to two results caused by one input byte.
    typedef struct packed {
        logic            has_err;
        logic            has_main;
        logic            main_status;
        logic [CP_W-1:0] main_cp;
    } entry_t;

    typedef enum logic [1:0] {
        ST_FIRST  = 2'b01,
        ST_SECOND = 2'b10
    } back_state_t;

endpackage

// File: design/u16d_front.sv
// ---------------------------------------------------------------------------
// u16d_front
// Accepts bytes, pairs them into units, classifies surrogates and builds
// one queue word per byte that yields results.
// ---------------------------------------------------------------------------
module u16d_front
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic                           cfg_wdata,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [7:0]                     data_byte,
    input  logic                           q_ready,
    output logic                           q_push,
    output u16d_pkg::entry_t               q_entry
);
    import u16d_pkg::*;

    logic               big_endian_reg;
    logic               byte_held_reg,  byte_held_next;
    logic [BYTE_W-1:0]  held_byte_reg,  held_byte_next;
    logic               hs_held_reg,    hs_held_next;
    logic [SUR_W-1:0]   hs_bits_reg,    hs_bits_next;

    logic               accept;
    logic [UNIT_W-1:0]  unit;
    logic               is_high;
    logic               is_low;
    logic [CP_W-1:0]    supp_cp;
    entry_t             entry;

    assign in_ready = q_ready;
    assign accept   = in_valid && in_ready;

    assign unit    = big_endian_reg ? {held_byte_reg, data_byte} : {data_byte, held_byte_reg};
    assign is_high = (unit[15:10] == SUR_HIGH_TAG);
    assign is_low  = (unit[15:10] == SUR_LOW_TAG);
    assign supp_cp = SUPP_BASE + {1'b0, hs_bits_reg, unit[SUR_W-1:0]};

    always_comb
    begin
        entry          = '0;
        byte_held_next = byte_held_reg;
        held_byte_next = held_byte_reg;
        hs_held_next   = hs_held_reg;
        hs_bits_next   = hs_bits_reg;
        if (accept)
        begin
            if (!byte_held_reg)
            begin
                byte_held_next = 1'b1;
                held_byte_next = data_byte;
            end
            else
            begin
                byte_held_next = 1'b0;
                hs_held_next   = 1'b0;
                hs_bits_next   = '0;
                if (hs_held_reg && is_low)
                begin
                    entry.has_main    = 1'b1;
                    entry.main_status = STATUS_OK;
                    entry.main_cp     = supp_cp;
                end
                else
                begin
                    entry.has_err = hs_held_reg;
                    if (is_high)
                    begin
                        hs_held_next = 1'b1;
                        hs_bits_next = unit[SUR_W-1:0];
                    end
                    else if (is_low)
                    begin
                        entry.has_main    = 1'b1;
                        entry.main_status = STATUS_ERR;
                    end
                    else
                    begin
                        entry.has_main    = 1'b1;
                        entry.main_status = STATUS_OK;
                        entry.main_cp     = {{(CP_W-UNIT_W){1'b0}}, unit};
                    end
                end
            end
        end
    end

    assign q_push  = accept && byte_held_reg && (entry.has_err || entry.has_main);
    assign q_entry = entry;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            big_endian_reg <= 1'b0;
            byte_held_reg  <= 1'b0;
            held_byte_reg  <= '0;
            hs_held_reg    <= 1'b0;
            hs_bits_reg    <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                big_endian_reg <= cfg_wdata;
            end
            byte_held_reg <= byte_held_next;
            held_byte_reg <= held_byte_next;
            hs_held_reg   <= hs_held_next;
            hs_bits_reg   <= hs_bits_next;
        end
    end

    a_push_on_second_byte: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> (accept && byte_held_reg))
        else $error("queue push without a completed unit");

    a_pending_bits_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !hs_held_reg |-> (hs_bits_reg == '0))
        else $error("surrogate bits kept with nothing pending");

endmodule

// File: design/u16d_queue.sv
// ---------------------------------------------------------------------------
// u16d_queue
// Small FIFO of decoded words between the front and back parts.
// ---------------------------------------------------------------------------
module u16d_queue
#(
    parameter int unsigned DEPTH = u16d_pkg::QUEUE_DEPTH
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  u16d_pkg::entry_t push_entry,
    output logic             push_ready,
    input  logic             pop,
    output logic             head_valid,
    output u16d_pkg::entry_t head_entry
);
    import u16d_pkg::*;

    localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    entry_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg,  count_next;

    logic do_push;
    logic do_pop;

    assign push_ready = (count_reg != CNT_FULL);
    assign head_valid = (count_reg != '0);
    assign head_entry = mem_reg[rd_ptr_reg];
    assign do_push    = push && push_ready;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_FULL)
        else $error("queue count beyond depth");

    a_ptr_agree: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == '0) |-> (wr_ptr_reg == rd_ptr_reg))
        else $error("empty queue with pointers apart");

endmodule

// File: design/u16d_back.sv
// ---------------------------------------------------------------------------
// u16d_back
// Drains queued words into result words, one result per cycle while out_ready is high.
// ---------------------------------------------------------------------------
module u16d_back
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             head_valid,
    input  u16d_pkg::entry_t head_entry,
    output logic             pop,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [20:0]      code_point,
    output logic             status,
    output logic             last
);
    import u16d_pkg::*;

    back_state_t state_reg, state_next;
    logic        show_err;
    logic        fire;

    assign show_err   = (state_reg == ST_FIRST) && head_entry.has_err;
    assign out_valid  = head_valid;
    assign code_point = show_err ? '0 : head_entry.main_cp;
    assign status     = show_err ? STATUS_ERR : head_entry.main_status;
    assign last       = show_err ? !head_entry.has_main : 1'b1;
    assign fire       = out_valid && out_ready;
    assign pop        = fire && last;

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_FIRST:
            begin
                if (fire && !last)
                begin
                    state_next = ST_SECOND;
                end
            end
            ST_SECOND:
            begin
                if (fire)
                begin
                    state_next = ST_FIRST;
                end
            end
            default:
            begin
                state_next = ST_FIRST;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_FIRST;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    a_second_needs_pair: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SECOND) |-> (head_valid && head_entry.has_err && head_entry.has_main))
        else $error("second result without a two-result word");

    a_err_word_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && status == STATUS_ERR) |-> (code_point == '0))
        else $error("error result with nonzero code point");

endmodule

// File: design/utf16_byte_stream_decoder.sv
// ---------------------------------------------------------------------------
// utf16_byte_stream_decoder
// UTF-16 byte stream to Unicode code point decoder, top level.
// ---------------------------------------------------------------------------
// One byte is taken per cycle while the result queue has room. The first
// byte of a unit gives nothing; the second gives zero, one or two results
// through a QUEUE_DEPTH-word FIFO. Results leave at one per cycle while
// out_ready is high, so a byte that gives two results (error for a dropped
// high surrogate, then the new unit) holds the output for both in turn;
// the FIFO absorbs that, and the sustained input rate is one byte per cycle
// unless the output side stalls. A result enters the FIFO when the second
// byte of its unit is accepted. cfg_we writes the byte order bit.
module utf16_byte_stream_decoder
#(
    parameter int unsigned QUEUE_DEPTH = u16d_pkg::QUEUE_DEPTH
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic        cfg_wdata,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [20:0] code_point,
    output logic        status,
    output logic        last
);
    import u16d_pkg::*;

    logic   q_push;
    logic   q_ready;
    entry_t q_entry;
    logic   q_pop;
    logic   head_valid;
    entry_t head_entry;

    u16d_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_entry   (q_entry)
    );

    u16d_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_entry (q_entry),
        .push_ready (q_ready),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_entry (head_entry)
    );

    u16d_back u_back
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_entry (head_entry),
        .pop        (q_pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_point (code_point),
        .status     (status),
        .last       (last)
    );

endmodule

// File: tb/utf16_byte_stream_decoder_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// utf16_byte_stream_decoder_tb
// Self-checking testbench for the UTF-16 byte stream decoder.
// Bytes go in through a valid/ready channel with random gaps. A predictor
// mirrors the unit pairing and surrogate handling and queues the expected
// code points. Each accepted output word is checked against the oldest entry.
// The byte order bit is written between phases while the block is idle.
// ---------------------------------------------------------------------------
module utf16_byte_stream_decoder_tb;

    import u16d_pkg::*;

    localparam int WATCHDOG_LIMIT = 3000;
    localparam int IDLE_SETTLE    = 4;

    typedef struct {
        logic [CP_W-1:0] cp;
        logic            status;
        logic            last;
    } cp_result_t;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic        cfg_wdata;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        out_valid;
    logic        out_ready;
    logic [20:0] code_point;
    logic        status;
    logic        last;

    // predictor state
    logic              order_be;
    logic              lead_held;
    logic [7:0]        lead_byte;
    logic              hi_pending;
    logic [SUR_W-1:0]  hi_bits;
    cp_result_t        expected_points[$];

    int   mismatch_count;
    int   idle_cycles;
    int   out_stall;
    int   bytes_sent;
    bit   no_gaps;
    cp_result_t head;

    utf16_byte_stream_decoder dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .cfg_wdata  (cfg_wdata),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .data_byte  (data_byte),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .code_point (code_point),
        .status     (status),
        .last       (last)
    );

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    function automatic int pick_gap();
        int r;
        if (no_gaps)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        else if (r < 88)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 40);
    endfunction

    function automatic void push_result(logic [CP_W-1:0] cp, logic st, logic lst);
        cp_result_t r;
        r.cp     = cp;
        r.status = st;
        r.last   = lst;
        expected_points.push_back(r);
    endfunction

    function automatic void decode_byte(logic [7:0] b);
        logic [UNIT_W-1:0] code_unit;
        if (!lead_held)
        begin
            lead_held = 1'b1;
            lead_byte = b;
            return;
        end
        lead_held = 1'b0;
        code_unit = order_be ? {lead_byte, b} : {b, lead_byte};

        if (hi_pending)
        begin
            hi_pending = 1'b0;
            if (code_unit[15:10] == SUR_LOW_TAG)
            begin
                push_result(SUPP_BASE + {1'b0, hi_bits, code_unit[9:0]}, STATUS_OK, 1'b1);
                hi_bits = '0;
                return;
            end
            hi_bits = '0;
            // dropped high surrogate; unit decoded afresh below
            push_result('0, STATUS_ERR, code_unit[15:10] == SUR_HIGH_TAG);
        end

        if (code_unit[15:10] == SUR_HIGH_TAG)
        begin
            hi_pending = 1'b1;
            hi_bits    = code_unit[9:0];
        end
        else if (code_unit[15:10] == SUR_LOW_TAG)
            push_result('0, STATUS_ERR, 1'b1);
        else
            push_result({5'd0, code_unit}, STATUS_OK, 1'b1);
    endfunction

    task automatic report_mismatch(input string what);
        $display("MISMATCH @%0t: %s", $time, what);
        mismatch_count++;
    endtask

    task automatic send_byte(input logic [7:0] b);
        int gap;
        gap = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid  <= 1'b1;
        data_byte <= b;
        do
            @(posedge clk);
        while (!in_ready);
        decode_byte(b);
        bytes_sent++;
    endtask

    task automatic send_unit(input logic [15:0] u);
        if (order_be)
        begin
            send_byte(u[15:8]);
            send_byte(u[7:0]);
        end
        else
        begin
            send_byte(u[7:0]);
            send_byte(u[15:8]);
        end
    endtask

    task automatic wait_idle();
        @(negedge clk);
        in_valid <= 1'b0;
        while (expected_points.size() != 0)
            @(posedge clk);
        repeat (IDLE_SETTLE) @(posedge clk);
    endtask

    task automatic write_byte_order(input logic be);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= be;
        @(negedge clk);
        cfg_we    <= 1'b0;
        order_be  = be;
    endtask

    task automatic test_little_endian_basics();
        send_unit(16'h0041);
        send_unit(16'hFFFF);
        send_unit(16'hD800);    // lowest pair -> 0x10000
        send_unit(16'hDC00);
        send_unit(16'hDC00);    // lone low surrogate
        send_unit(16'hD800);    // high then plain unit
        send_unit(16'h0041);
        send_unit(16'hD800);    // high then high, then low -> 0x10FFFF
        send_unit(16'hDBFF);
        send_unit(16'hDFFF);
        wait_idle();
    endtask

    task automatic test_big_endian_basics();
        write_byte_order(1'b1);
        send_unit(16'h0000);
        send_unit(16'hD7FF);
        send_unit(16'hE000);
        send_unit(16'hD83D);
        send_unit(16'hDE00);
        wait_idle();
    endtask

    task automatic test_order_switch_mid_unit();
        send_byte(8'h12);
        wait_idle();
        write_byte_order(1'b0);
        send_byte(8'h34);
        send_byte(8'h56);
        wait_idle();
        write_byte_order(1'b1);
        send_byte(8'h78);
        wait_idle();
    endtask

    task automatic send_random_item();
        int r;
        logic [15:0] u;
        r = $urandom_range(0, 99);
        if (r < 45)
        begin
            do
                u = 16'($urandom_range(0, 65535));
            while (u[15:11] == 5'b11011);
            send_unit(u);
        end
        else if (r < 75)
        begin
            send_unit({SUR_HIGH_TAG, 10'($urandom_range(0, 1023))});
            send_unit({SUR_LOW_TAG, 10'($urandom_range(0, 1023))});
        end
        else if (r < 83)
            send_unit({SUR_HIGH_TAG, 10'($urandom_range(0, 1023))});
        else if (r < 89)
            send_unit({SUR_LOW_TAG, 10'($urandom_range(0, 1023))});
        else if (r < 93)
            send_unit($urandom_range(0, 1) ? 16'hFFFF : 16'h0000);
        else
            send_byte(8'($urandom_range(0, 255)));   // shifts unit alignment
    endtask

    task automatic test_random_stream();
        int phase;
        int target;
        for (phase = 0; phase < 8; phase++)
        begin
            if (phase < 2)
                write_byte_order(phase[0]);
            else
                write_byte_order($urandom_range(0, 1));
            no_gaps = (phase % 4 == 3);
            target  = bytes_sent + 190;
            while (bytes_sent < target)
                send_random_item();
            wait_idle();
        end
        no_gaps = 1'b0;
    endtask

    always @(negedge clk)
    begin
        if (out_stall > 0)
        begin
            out_ready <= 1'b0;
            out_stall--;
        end
        else
        begin
            out_ready <= 1'b1;
            out_stall = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && out_ready)
        begin
            if (expected_points.size() == 0)
                report_mismatch($sformatf("unexpected word cp=%h status=%b last=%b",
                                          code_point, status, last));
            else
            begin
                head = expected_points.pop_front();
                if (code_point !== head.cp)
                    report_mismatch($sformatf("code_point %h, expected %h",
                                              code_point, head.cp));
                if (status !== head.status)
                    report_mismatch($sformatf("status %b, expected %b",
                                              status, head.status));
                if (last !== head.last)
                    report_mismatch($sformatf("last %b, expected %b", last, head.last));
            end
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Verification failed");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        cfg_we         = 1'b0;
        cfg_wdata      = 1'b0;
        in_valid       = 1'b0;
        data_byte      = 8'h00;
        out_ready      = 1'b0;
        order_be       = 1'b0;
        lead_held      = 1'b0;
        lead_byte      = 8'h00;
        hi_pending     = 1'b0;
        hi_bits        = '0;
        mismatch_count = 0;
        idle_cycles    = 0;
        out_stall      = 0;
        bytes_sent     = 0;
        no_gaps        = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_little_endian_basics();
        test_big_endian_basics();
        test_order_switch_mid_unit();
        test_random_stream();

        if (mismatch_count == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
